// ===== sv/sqch_pkg.sv =====
// shared types, codes and tables for the square channel with sweep
`default_nettype none

package sqch_pkg;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_SWEEP = 2'd2,
        MODE_CLOCK = 2'd3
    } mode_t;

    localparam logic [2:0] REG_SWEEP       = 3'd0;
    localparam logic [2:0] REG_DUTY_LENGTH = 3'd1;
    localparam logic [2:0] REG_VOLUME      = 3'd2;
    localparam logic [2:0] REG_PERIOD_LOW  = 3'd3;
    localparam logic [2:0] REG_PERIOD_HIGH = 3'd4;

    localparam logic [7:0] READ_UNMAPPED = 8'hff;

    // settings the waveform generator takes from the register block
    typedef struct packed {
        logic [10:0] period;
        logic [1:0]  duty;
        logic [3:0]  level;
    } wave_ctrl_t;

    function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
        logic [7:0] pat;
        case (sel)
            2'd0:    pat = 8'h80;
            2'd1:    pat = 8'h81;
            2'd2:    pat = 8'he1;
            default: pat = 8'h7e;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ===== sv/sqch_if.sv =====
// beat interfaces for the command and response channels
`default_nettype none

interface sqch_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [2:0] reg_index;
    logic [7:0] write_data;

    modport source (output valid, output mode, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input mode, input reg_index, input write_data,
                    output ready);
endinterface

interface sqch_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       channel_on;
    logic       dac_on;
    logic [3:0] sample_out;

    modport source (output valid, output read_data, output channel_on, output dac_on,
                    output sample_out, input ready);
    modport sink   (input valid, input read_data, input channel_on, input dac_on,
                    input sample_out, output ready);
endinterface

`default_nettype wire

// ===== sv/sqch_regs.sv =====
// register file, trigger logic and frequency sweep unit
`default_nettype none

module sqch_regs (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire sqch_pkg::mode_t     mode,
    input  wire logic [2:0]          reg_index,
    input  wire logic [7:0]          write_data,
    output sqch_pkg::wave_ctrl_t     ctrl,
    output logic [7:0]               read_value,
    output logic                     active,
    output logic                     dac
);

    logic [7:0] sweep_reg, sweep_next;
    logic [7:0] duty_length_reg, duty_length_next;
    logic [7:0] volume_reg, volume_next;
    logic [7:0] period_low_reg, period_low_next;
    logic [7:0] period_high_reg, period_high_next;
    logic [3:0] level_reg, level_next;
    logic [2:0] sweep_count_reg, sweep_count_next;
    logic       active_reg, active_next;
    logic       dac_reg, dac_next;

    logic [10:0] period;
    logic [10:0] diff;
    logic [11:0] swept;
    logic [2:0]  count_loaded;
    logic [2:0]  count_dec;

    assign period = {period_high_reg[2:0], period_low_reg};
    assign diff   = period >> sweep_reg[2:0];
    // subtracting never wraps since diff never exceeds period
    assign swept  = sweep_reg[3] ? ({1'b0, period} - {1'b0, diff})
                                 : ({1'b0, period} + {1'b0, diff});
    assign count_loaded = (sweep_count_reg == 3'd0) ? sweep_reg[6:4] : sweep_count_reg;
    assign count_dec    = count_loaded - 3'd1;

    always_comb
    begin
        sweep_next       = sweep_reg;
        duty_length_next = duty_length_reg;
        volume_next      = volume_reg;
        period_low_next  = period_low_reg;
        period_high_next = period_high_reg;
        level_next       = level_reg;
        sweep_count_next = sweep_count_reg;
        active_next      = active_reg;
        dac_next         = dac_reg;
        if (accept)
        begin
            unique case (mode)
                sqch_pkg::MODE_WRITE:
                begin
                    unique case (reg_index)
                        sqch_pkg::REG_SWEEP:       sweep_next = write_data;
                        sqch_pkg::REG_DUTY_LENGTH: duty_length_next = write_data;
                        sqch_pkg::REG_VOLUME:
                        begin
                            volume_next = write_data;
                            level_next  = write_data[7:4];
                            dac_next    = |write_data[7:3];
                            if (!(|write_data[7:3]))
                            begin
                                active_next = 1'b0;
                            end
                        end
                        sqch_pkg::REG_PERIOD_LOW:  period_low_next = write_data;
                        sqch_pkg::REG_PERIOD_HIGH:
                        begin
                            period_high_next = write_data;
                            if (write_data[7])
                            begin
                                if (dac_reg)
                                begin
                                    active_next = 1'b1;
                                end
                                sweep_count_next = sweep_reg[6:4];
                            end
                        end
                        default: ;
                    endcase
                end
                sqch_pkg::MODE_SWEEP:
                begin
                    sweep_count_next = count_loaded;
                    if (swept[11])
                    begin
                        active_next = 1'b0;
                    end
                    if (count_loaded != 3'd0)
                    begin
                        sweep_count_next = count_dec;
                        // write-back keeps only eleven bits of the swept period
                        if (count_dec == 3'd0)
                        begin
                            period_low_next  = swept[7:0];
                            period_high_next = {period_high_reg[7:3], swept[10:8]};
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg       <= '0;
            duty_length_reg <= '0;
            volume_reg      <= '0;
            period_low_reg  <= '0;
            period_high_reg <= '0;
            level_reg       <= '0;
            sweep_count_reg <= '0;
            active_reg      <= 1'b0;
            dac_reg         <= 1'b0;
        end
        else
        begin
            sweep_reg       <= sweep_next;
            duty_length_reg <= duty_length_next;
            volume_reg      <= volume_next;
            period_low_reg  <= period_low_next;
            period_high_reg <= period_high_next;
            level_reg       <= level_next;
            sweep_count_reg <= sweep_count_next;
            active_reg      <= active_next;
            dac_reg         <= dac_next;
        end
    end

    always_comb
    begin
        unique case (reg_index)
            sqch_pkg::REG_SWEEP:       read_value = sweep_reg;
            sqch_pkg::REG_DUTY_LENGTH: read_value = duty_length_reg;
            sqch_pkg::REG_VOLUME:      read_value = volume_reg;
            sqch_pkg::REG_PERIOD_HIGH: read_value = period_high_reg;
            default:                   read_value = sqch_pkg::READ_UNMAPPED;
        endcase
    end

    assign ctrl.period = period;
    assign ctrl.duty   = duty_length_reg[7:6];
    assign ctrl.level  = level_reg;
    assign active      = active_reg;
    assign dac         = dac_reg;

endmodule

`default_nettype wire

// ===== sv/sqch_wave.sv =====
// prescaler, period counter and duty sequencer
`default_nettype none

module sqch_wave #(
    parameter int PRESCALE = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 tick,
    input  wire sqch_pkg::wave_ctrl_t ctrl,
    output logic [3:0]                sample
);

    localparam int PW = $clog2(PRESCALE + 1);

    logic [PW-1:0] prescale_reg, prescale_next;
    logic [PW-1:0] prescale_inc;
    logic [10:0]   period_count_reg, period_count_next;
    logic [11:0]   period_inc;
    logic [2:0]    duty_step_reg, duty_step_next;
    logic [3:0]    sample_reg, sample_next;
    logic [7:0]    pattern;

    assign prescale_inc = prescale_reg + PW'(1);
    assign period_inc   = {1'b0, period_count_reg} + 12'd1;
    assign pattern      = sqch_pkg::duty_pattern(ctrl.duty);

    always_comb
    begin
        prescale_next     = prescale_reg;
        period_count_next = period_count_reg;
        duty_step_next    = duty_step_reg;
        sample_next       = sample_reg;
        if (tick)
        begin
            prescale_next = prescale_inc;
            // the sequencer steps on the first prescaler count of a matching period
            if (prescale_inc == PW'(1) && period_count_reg == ctrl.period)
            begin
                sample_next    = pattern[duty_step_reg] ? ctrl.level : 4'd0;
                duty_step_next = duty_step_reg + 3'd1;
            end
            if (prescale_inc >= PW'(PRESCALE))
            begin
                prescale_next     = '0;
                period_count_next = period_inc[11] ? ctrl.period : period_inc[10:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg     <= '0;
            period_count_reg <= '0;
            duty_step_reg    <= '0;
            sample_reg       <= '0;
        end
        else
        begin
            prescale_reg     <= prescale_next;
            period_count_reg <= period_count_next;
            duty_step_reg    <= duty_step_next;
            sample_reg       <= sample_next;
        end
    end

    assign sample = sample_reg;

endmodule

`default_nettype wire

// ===== sv/square_channel_with_sweep.sv =====
// top level of the square channel with sweep
`default_nettype none

// Pulse channel with frequency sweep. Every command beat (register write,
// register read, sweep tick or clock tick) yields exactly one response beat.
// A command is taken in every cycle while the response register is empty or
// being drained, so the sustained rate is one beat per clock; the response
// appears in the cycle after its command is taken. The whole update of the
// channel state is registered together with the response, and the channel
// flags and sample in the response are the state left by the command.
// read_data is zero on everything but reads. PRESCALE sets how many clock
// ticks make one step of the period counter.
module square_channel_with_sweep #(
    parameter int PRESCALE = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sqch_cmd_if.sink   cmd,
    sqch_rsp_if.source rsp
);

    logic                 accept;
    sqch_pkg::mode_t      mode;
    sqch_pkg::wave_ctrl_t ctrl;
    logic [7:0]           read_value;
    logic                 active;
    logic                 dac;
    logic [3:0]           sample;
    logic                 valid_reg, valid_next;
    logic [7:0]           read_data_reg;

    assign mode      = sqch_pkg::mode_t'(cmd.mode);
    assign cmd.ready = !valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    sqch_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .mode       (mode),
        .reg_index  (cmd.reg_index),
        .write_data (cmd.write_data),
        .ctrl       (ctrl),
        .read_value (read_value),
        .active     (active),
        .dac        (dac)
    );

    sqch_wave #(
        .PRESCALE (PRESCALE)
    ) u_wave (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (accept && mode == sqch_pkg::MODE_CLOCK),
        .ctrl   (ctrl),
        .sample (sample)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= (mode == sqch_pkg::MODE_READ) ? read_value : 8'd0;
        end
    end

    // state only moves when a new beat is taken, which reloads the response too
    assign rsp.valid      = valid_reg;
    assign rsp.read_data  = read_data_reg;
    assign rsp.channel_on = active;
    assign rsp.dac_on     = dac;
    assign rsp.sample_out = sample;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for the pulse channel with frequency sweep
`timescale 1ns / 100ps

module testbench;

    localparam int          PRESCALE    = 4;
    localparam logic [11:0] PERIOD_MAX  = 12'h7ff;
    localparam logic [11:0] PERIOD_WRAP = 12'd2048;
    localparam logic [7:0]  DUTY_WAVES [4] = '{8'h80, 8'h81, 8'he1, 8'h7e};

    typedef struct packed {
        logic [7:0] read_data;
        logic       channel_on;
        logic       dac_on;
        logic [3:0] sample_out;
    } chan_resp_t;

    logic clk;
    logic rst_n;

    sqch_cmd_if cmd_bus ();
    sqch_rsp_if rsp_bus ();

    square_channel_with_sweep #(
        .PRESCALE(PRESCALE)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd_bus),
        .rsp(rsp_bus)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // shadow of the channel state
    logic [7:0]  ch_sweep     = '0;
    logic [7:0]  ch_duty_len  = '0;
    logic [7:0]  ch_volume    = '0;
    logic [7:0]  ch_per_lo    = '0;
    logic [7:0]  ch_per_hi    = '0;
    logic [3:0]  ch_level     = '0;
    logic [2:0]  ch_pace      = '0;
    logic        ch_active    = 1'b0;
    logic        ch_dac       = 1'b0;
    int unsigned ch_prescale  = 0;
    logic [11:0] ch_per_count = '0;
    logic [2:0]  ch_step      = '0;
    logic [3:0]  ch_sample    = '0;

    chan_resp_t  awaited_resp [$];
    bit          gaps_on = 1'b1;
    int unsigned resp_stall = 0;
    int unsigned resp_seen = 0;
    int unsigned error_count = 0;

    function automatic chan_resp_t advance_channel(input sqch_pkg::mode_t m,
                                                   input logic [2:0] idx,
                                                   input logic [7:0] data);
        chan_resp_t  r;
        logic [11:0] per;
        logic [11:0] delta;
        logic [11:0] nxt;
        logic [7:0]  wave;
        r.read_data = 8'h00;
        per = {1'b0, ch_per_hi[2:0], ch_per_lo};
        case (m)
            sqch_pkg::MODE_WRITE:
            begin
                case (idx)
                    sqch_pkg::REG_SWEEP:       ch_sweep = data;
                    sqch_pkg::REG_DUTY_LENGTH: ch_duty_len = data;
                    sqch_pkg::REG_VOLUME:
                    begin
                        ch_volume = data;
                        ch_level  = data[7:4];
                        ch_dac    = (data[7:3] != 5'd0);
                        if (!ch_dac)
                            ch_active = 1'b0;
                    end
                    sqch_pkg::REG_PERIOD_LOW:  ch_per_lo = data;
                    sqch_pkg::REG_PERIOD_HIGH:
                    begin
                        ch_per_hi = data;
                        if (data[7])
                        begin
                            if (ch_dac)
                                ch_active = 1'b1;
                            ch_pace = ch_sweep[6:4];
                        end
                    end
                    default: ;
                endcase
            end
            sqch_pkg::MODE_READ:
            begin
                case (idx)
                    sqch_pkg::REG_SWEEP:       r.read_data = ch_sweep;
                    sqch_pkg::REG_DUTY_LENGTH: r.read_data = ch_duty_len;
                    sqch_pkg::REG_VOLUME:      r.read_data = ch_volume;
                    sqch_pkg::REG_PERIOD_HIGH: r.read_data = ch_per_hi;
                    default:                   r.read_data = sqch_pkg::READ_UNMAPPED;
                endcase
            end
            sqch_pkg::MODE_SWEEP:
            begin
                if (ch_pace == 3'd0)
                    ch_pace = ch_sweep[6:4];
                delta = per >> ch_sweep[2:0];
                nxt   = ch_sweep[3] ? per - delta : per + delta;
                if (nxt > PERIOD_MAX)
                    ch_active = 1'b0;
                if (ch_pace != 3'd0)
                begin
                    ch_pace = ch_pace - 3'd1;
                    // write-back keeps only 11 bits, the carry never reaches bit 3
                    if (ch_pace == 3'd0)
                    begin
                        ch_per_lo = nxt[7:0];
                        ch_per_hi = {ch_per_hi[7:3], nxt[10:8]};
                    end
                end
            end
            sqch_pkg::MODE_CLOCK:
            begin
                ch_prescale++;
                if (ch_prescale == 1 && ch_per_count == per)
                begin
                    wave      = DUTY_WAVES[ch_duty_len[7:6]];
                    ch_sample = wave[ch_step] ? ch_level : 4'd0;
                    ch_step   = ch_step + 3'd1;
                end
                if (ch_prescale >= PRESCALE)
                begin
                    ch_per_count = ch_per_count + 12'd1;
                    if (ch_per_count >= PERIOD_WRAP)
                        ch_per_count = per;
                    ch_prescale = 0;
                end
            end
        endcase
        r.channel_on = ch_active;
        r.dac_on     = ch_dac;
        r.sample_out = ch_sample;
        return r;
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%t: %s", $realtime, msg);
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input sqch_pkg::mode_t m, input logic [2:0] idx,
                             input logic [7:0] data);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 8) : 0;
        if (gap != 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.mode       <= m;
        cmd_bus.reg_index  <= idx;
        cmd_bus.write_data <= data;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        awaited_resp.push_back(advance_channel(m, idx, data));
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        send_beat(sqch_pkg::MODE_WRITE, idx, data);
    endtask

    task automatic read_reg(input logic [2:0] idx);
        send_beat(sqch_pkg::MODE_READ, idx, 8'($urandom_range(0, 255)));
    endtask

    task automatic sweep_tick();
        send_beat(sqch_pkg::MODE_SWEEP, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    endtask

    task automatic clock_tick();
        send_beat(sqch_pkg::MODE_CLOCK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    endtask

    // response side: stall draw per beat, ready moves on the falling edge
    always @(negedge clk)
    begin
        if (resp_stall != 0)
        begin
            rsp_bus.ready <= 1'b0;
            resp_stall--;
        end
        else
            rsp_bus.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        chan_resp_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            resp_stall = gaps_on ? $urandom_range(0, 8) : 0;
            resp_seen++;
            if (awaited_resp.size() == 0)
                note_error($sformatf("beat %0d arrived with nothing outstanding", resp_seen));
            else
            begin
                want = awaited_resp.pop_front();
                if (rsp_bus.read_data !== want.read_data || rsp_bus.channel_on !== want.channel_on
                    || rsp_bus.dac_on !== want.dac_on || rsp_bus.sample_out !== want.sample_out)
                    note_error($sformatf({"beat %0d mismatch: want rd=%02h on=%0b dac=%0b smp=%0h",
                                          ", got rd=%02h on=%0b dac=%0b smp=%0h"},
                                         resp_seen, want.read_data, want.channel_on, want.dac_on,
                                         want.sample_out, rsp_bus.read_data, rsp_bus.channel_on,
                                         rsp_bus.dac_on, rsp_bus.sample_out));
            end
        end
    end

    task automatic check_register_file();
        write_reg(sqch_pkg::REG_SWEEP, 8'h00);
        read_reg(sqch_pkg::REG_SWEEP);
        write_reg(sqch_pkg::REG_SWEEP, 8'hff);
        read_reg(sqch_pkg::REG_SWEEP);
        write_reg(sqch_pkg::REG_DUTY_LENGTH, 8'h00);
        write_reg(sqch_pkg::REG_DUTY_LENGTH, 8'hff);
        read_reg(sqch_pkg::REG_DUTY_LENGTH);
        write_reg(sqch_pkg::REG_VOLUME, 8'hff);
        read_reg(sqch_pkg::REG_VOLUME);
        write_reg(sqch_pkg::REG_PERIOD_LOW, 8'hff);
        read_reg(sqch_pkg::REG_PERIOD_LOW);
        write_reg(sqch_pkg::REG_PERIOD_HIGH, 8'h7f);
        read_reg(sqch_pkg::REG_PERIOD_HIGH);
        write_reg(sqch_pkg::REG_PERIOD_HIGH, 8'hff);
        read_reg(sqch_pkg::REG_PERIOD_HIGH);
        // indices past the register file
        write_reg(3'd5, 8'h00);
        write_reg(3'd6, 8'hff);
        write_reg(3'd7, 8'h5a);
        read_reg(3'd5);
        read_reg(3'd6);
        read_reg(3'd7);
        write_reg(sqch_pkg::REG_PERIOD_LOW, 8'h00);
        write_reg(sqch_pkg::REG_PERIOD_HIGH, 8'h00);
        read_reg(sqch_pkg::REG_PERIOD_HIGH);
    endtask

    task automatic check_dac_and_trigger();
        write_reg(sqch_pkg::REG_VOLUME, 8'h07);
        read_reg(sqch_pkg::REG_VOLUME);
        // trigger with the dac off leaves the channel silent
        write_reg(sqch_pkg::REG_PERIOD_HIGH, 8'h80);
        write_reg(sqch_pkg::REG_VOLUME, 8'h08);
        write_reg(sqch_pkg::REG_PERIOD_HIGH, 8'hc0);
        write_reg(sqch_pkg::REG_VOLUME, 8'h00);
        write_reg(sqch_pkg::REG_VOLUME, 8'hf8);
        write_reg(sqch_pkg::REG_PERIOD_HIGH, 8'h80);
        send_beat(sqch_pkg::MODE_SWEEP, 3'd7, 8'hff);
        send_beat(sqch_pkg::MODE_SWEEP, 3'd0, 8'h00);
        send_beat(sqch_pkg::MODE_CLOCK, 3'd7, 8'hff);
        send_beat(sqch_pkg::MODE_CLOCK, 3'd0, 8'h00);
        read_reg(sqch_pkg::REG_PERIOD_HIGH);
    endtask

    task automatic check_sweep_unit();
        write_reg(sqch_pkg::REG_SWEEP, 8'h00);
        write_reg(sqch_pkg::REG_PERIOD_LOW, 8'hff);
        write_reg(sqch_pkg::REG_VOLUME, 8'hf0);
        write_reg(sqch_pkg::REG_PERIOD_HIGH, 8'h87);
        // pace zero: overflow still switches off, period untouched
        sweep_tick();
        read_reg(sqch_pkg::REG_PERIOD_HIGH);
        write_reg(sqch_pkg::REG_SWEEP, 8'h10);
        write_reg(sqch_pkg::REG_PERIOD_HIGH, 8'h87);
        sweep_tick();
        read_reg(sqch_pkg::REG_PERIOD_HIGH);
        write_reg(sqch_pkg::REG_SWEEP, 8'h19);
        write_reg(sqch_pkg::REG_PERIOD_HIGH, 8'h87);
        sweep_tick();
        read_reg(sqch_pkg::REG_PERIOD_HIGH);
        write_reg(sqch_pkg::REG_SWEEP, 8'h7f);
        write_reg(sqch_pkg::REG_PERIOD_HIGH, 8'hff);
        sweep_tick();
        sweep_tick();
        read_reg(sqch_pkg::REG_PERIOD_HIGH);
        write_reg(sqch_pkg::REG_SWEEP, 8'h21);
        write_reg(sqch_pkg::REG_PERIOD_HIGH, 8'h84);
        sweep_tick();
        sweep_tick();
        read_reg(sqch_pkg::REG_PERIOD_HIGH);
    endtask

    // the period is aimed at the counter so each run of ticks lands a sequencer step
    task automatic check_duty_sequencer();
        logic [11:0] target;
        write_reg(sqch_pkg::REG_SWEEP, 8'h00);
        write_reg(sqch_pkg::REG_VOLUME, 8'hf8);
        write_reg(sqch_pkg::REG_PERIOD_HIGH, 8'h80);
        for (int i = 0; i < 48; i++)
        begin
            gaps_on = (i % 16) < 8;
            if (i % 8 == 0)
                write_reg(sqch_pkg::REG_DUTY_LENGTH, {2'(i / 8), 6'd0});
            if (i == 24)
                write_reg(sqch_pkg::REG_VOLUME, 8'h90);
            // overflow stops the channel, the sequencer keeps going
            if (i == 32)
            begin
                write_reg(sqch_pkg::REG_PERIOD_HIGH, 8'h07);
                sweep_tick();
            end
            if (i == 40)
                write_reg(sqch_pkg::REG_PERIOD_HIGH, 8'h80);
            target = ch_per_count + ((ch_prescale != 0) ? 12'd1 : 12'd0);
            write_reg(sqch_pkg::REG_PERIOD_LOW, target[7:0]);
            write_reg(sqch_pkg::REG_PERIOD_HIGH, {5'd0, target[10:8]});
            repeat (4) clock_tick();
        end
        gaps_on = 1'b1;
    endtask

    task automatic check_random_traffic();
        int unsigned pick;
        logic [2:0]  idx;
        logic [7:0]  data;
        for (int i = 0; i < 450; i++)
        begin
            if (i % 100 == 0)
                gaps_on = $urandom_range(0, 2) != 0;
            pick = $urandom_range(0, 99);
            if (pick < 55)
                clock_tick();
            else if (pick < 70)
                sweep_tick();
            else if (pick < 88)
            begin
                idx  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
                data = 8'($urandom_range(0, 255));
                // aim the period at the counter now and then so the sequencer steps
                if (idx == sqch_pkg::REG_PERIOD_LOW && $urandom_range(0, 1) != 0)
                    data = ch_per_count[7:0] + 8'd1;
                if (idx == sqch_pkg::REG_PERIOD_HIGH && $urandom_range(0, 1) != 0)
                    data[2:0] = ch_per_count[10:8];
                write_reg(idx, data);
            end
            else
                read_reg(3'($urandom_range(0, 7)));
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.mode       = sqch_pkg::MODE_WRITE;
        cmd_bus.reg_index  = 3'd0;
        cmd_bus.write_data = 8'h00;
        rsp_bus.ready      = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_register_file();
        check_dac_and_trigger();
        check_sweep_unit();
        check_duty_sequencer();
        check_random_traffic();
        cmd_bus.valid <= 1'b0;

        for (int n = 0; n < 1000 && awaited_resp.size() != 0; n++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (awaited_resp.size() != 0)
            note_error($sformatf("%0d beats never came back", awaited_resp.size()));
        if (error_count == 0)
            $display("square_channel_with_sweep regression: pass");
        else
            $display("square_channel_with_sweep regression: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("square_channel_with_sweep regression: fail");
        $finish;
    end

endmodule
